// ===== hw/rtl/dit_pkg.sv =====
// Package for the disjoint interval tracker: result status codes, cell
// commands, update modes and the flag group each cell reports.
// No dependencies; used by dit_cell and disjoint_interval_tracker.
package dit_pkg;

  // Result status codes carried on the master-side tuser
  localparam logic [2:0] STATUS_ADDED   = 3'd0;
  localparam logic [2:0] STATUS_COVERED = 3'd1;
  localparam logic [2:0] STATUS_FULL    = 3'd2;
  localparam logic [2:0] STATUS_REPORT  = 3'd3;
  localparam logic [2:0] STATUS_EMPTY   = 3'd4;

  // Operation codes carried on the slave-side tuser
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // What every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_UPDATE,
    CELL_ROTATE
  } cell_op_e;

  // How the table changes when an added value is applied
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_HIGH,
    UPD_LOW,
    UPD_MERGE,
    UPD_INSERT
  } upd_mode_e;

  // Command broadcast from the controller to all cells
  typedef struct packed {
    cell_op_e  op;
    upd_mode_e mode;
  } cell_ctrl_t;

  // Flags each cell holds after a compare
  typedef struct packed {
    logic valid;
    logic lt;
    logic cov;
    logic below;
    logic above;
  } cell_flags_t;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_RPT  = 4'b0100,
    ST_SPARE = 4'b1000
  } state_e;

endpackage

// ===== hw/rtl/dit_cell.sv =====
// One cell of the interval chain: holds one interval, compares it with a
// broadcast value and takes data from its neighbours on update or rotate.
// Depends on dit_pkg.
module dit_cell #(
  parameter int VALUE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dit_pkg::cell_ctrl_t     ctrl_i,
  input  logic [VALUE_BITS-1:0]   value_i,
  // Neighbour below (lower index)
  input  logic                    prev_valid_i,
  input  logic                    prev_lt_i,
  input  logic [VALUE_BITS-1:0]   prev_lo_i,
  input  logic [VALUE_BITS-1:0]   prev_hi_i,
  // Neighbour above (higher index)
  input  logic                    next_valid_i,
  input  logic [VALUE_BITS-1:0]   next_lo_i,
  input  logic [VALUE_BITS-1:0]   next_hi_i,
  // Head of the chain, used when rotating
  input  logic [VALUE_BITS-1:0]   head_lo_i,
  input  logic [VALUE_BITS-1:0]   head_hi_i,
  output dit_pkg::cell_flags_t    flags_o,
  output logic [VALUE_BITS-1:0]   lo_o,
  output logic [VALUE_BITS-1:0]   hi_o
);
  import dit_pkg::*;

  logic                  valid_q, valid_d;
  logic [VALUE_BITS-1:0] lo_q, lo_d;
  logic [VALUE_BITS-1:0] hi_q, hi_d;
  logic                  lt_q, lt_d;
  logic                  cov_q, cov_d;
  logic                  below_q, below_d;
  logic                  above_q, above_d;

  // Comparisons of the held interval against the broadcast value
  always_comb begin
    lt_d    = lt_q;
    cov_d   = cov_q;
    below_d = below_q;
    above_d = above_q;
    if (ctrl_i.op == CELL_CMP) begin
      lt_d    = valid_q && (lo_q < value_i);
      cov_d   = valid_q && (lo_q <= value_i) && (value_i <= hi_q);
      below_d = valid_q && (({1'b0, hi_q} + 1'b1) == {1'b0, value_i});
      above_d = valid_q && ({1'b0, lo_q} == ({1'b0, value_i} + 1'b1));
    end
  end

  // Interval update, either from an add or from one step of a report
  always_comb begin
    valid_d = valid_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    case (ctrl_i.op)
      CELL_UPDATE: begin
        case (ctrl_i.mode)
          UPD_HIGH: begin
            if (below_q) begin
              hi_d = value_i;
            end
          end
          UPD_LOW: begin
            if (above_q) begin
              lo_d = value_i;
            end
          end
          UPD_MERGE: begin
            // The lower interval absorbs the upper one; the rest move down.
            if (below_q) begin
              hi_d = next_hi_i;
            end else if (valid_q && !lt_q) begin
              valid_d = next_valid_i;
              lo_d    = next_lo_i;
              hi_d    = next_hi_i;
            end
          end
          UPD_INSERT: begin
            // Intervals above the new value move up by one place.
            if (prev_valid_i && !prev_lt_i) begin
              valid_d = 1'b1;
              lo_d    = prev_lo_i;
              hi_d    = prev_hi_i;
            end else if (!lt_q && prev_lt_i) begin
              valid_d = 1'b1;
              lo_d    = value_i;
              hi_d    = value_i;
            end
          end
          default: begin
          end
        endcase
      end
      CELL_ROTATE: begin
        // The chain rotates down; the last valid cell takes the head.
        if (next_valid_i) begin
          lo_d = next_lo_i;
          hi_d = next_hi_i;
        end else if (valid_q) begin
          lo_d = head_lo_i;
          hi_d = head_hi_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
      lt_q    <= 1'b0;
      cov_q   <= 1'b0;
      below_q <= 1'b0;
      above_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      lt_q    <= lt_d;
      cov_q   <= cov_d;
      below_q <= below_d;
      above_q <= above_d;
    end
  end

  assign flags_o.valid = valid_q;
  assign flags_o.lt    = lt_q;
  assign flags_o.cov   = cov_q;
  assign flags_o.below = below_q;
  assign flags_o.above = above_q;
  assign lo_o          = lo_q;
  assign hi_o          = hi_q;

endmodule

// ===== hw/rtl/disjoint_interval_tracker.sv =====
// Disjoint interval tracker, top level: controller, output register and a
// chain of dit_cell instances. Depends on dit_pkg and dit_cell.
//
// On an add, the value is compared in every cell in the cycle the transaction
// is accepted, and the chain is updated in ST_UPD once the output register is
// free, when its status result is written to the output register. A report
// emits one interval per cycle while the output is free, the chain rotating by
// one cell per interval: one result per stored interval, or an empty-status
// result for an empty table. The next input transaction is taken once the
// chain is back in its idle state, even while the last result still waits at
// the output. The table is empty after reset and needs no clearing pass.
module disjoint_interval_tracker #(
  parameter int MAX_INTERVALS = 32,
  parameter int VALUE_BITS    = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: value
  input  logic [((VALUE_BITS+7)/8)*8-1:0]        s_axis_tdata,
  // tuser: operation
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata: range_low, range_high
  output logic [((2*VALUE_BITS+7)/8)*8-1:0]      m_axis_tdata,
  // tuser: status
  output logic [2:0]                             m_axis_tuser,
  output logic                                   m_axis_tlast
);
  import dit_pkg::*;

  localparam int CW    = $clog2(MAX_INTERVALS + 1);
  localparam int OUT_W = ((2*VALUE_BITS+7)/8)*8;

  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         rpt_idx_q, rpt_idx_d;

  logic                  out_valid_q, out_valid_d;
  logic [2:0]            out_status_q, out_status_d;
  logic [VALUE_BITS-1:0] out_lo_q, out_lo_d;
  logic [VALUE_BITS-1:0] out_hi_q, out_hi_d;
  logic                  out_last_q, out_last_d;

  cell_ctrl_t            ctrl;
  logic [VALUE_BITS-1:0] cell_value;
  logic                  in_fire;
  logic                  out_free;
  logic                  any_cov, any_below, any_above;
  logic                  rpt_last;

  cell_flags_t           flags [MAX_INTERVALS];
  logic [VALUE_BITS-1:0] lo    [MAX_INTERVALS];
  logic [VALUE_BITS-1:0] hi    [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] cov_vec, below_vec, above_vec;

  // The chain of cells with its boundary neighbours
  for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
    logic                  p_valid, p_lt, n_valid;
    logic [VALUE_BITS-1:0] p_lo, p_hi, n_lo, n_hi;

    if (g == 0) begin : g_first
      assign p_valid = 1'b0;
      assign p_lt    = 1'b1;
      assign p_lo    = '0;
      assign p_hi    = '0;
    end else begin : g_mid_lo
      assign p_valid = flags[g-1].valid;
      assign p_lt    = flags[g-1].lt;
      assign p_lo    = lo[g-1];
      assign p_hi    = hi[g-1];
    end

    if (g == MAX_INTERVALS - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_lo    = '0;
      assign n_hi    = '0;
    end else begin : g_mid_hi
      assign n_valid = flags[g+1].valid;
      assign n_lo    = lo[g+1];
      assign n_hi    = hi[g+1];
    end

    dit_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .value_i      (cell_value),
      .prev_valid_i (p_valid),
      .prev_lt_i    (p_lt),
      .prev_lo_i    (p_lo),
      .prev_hi_i    (p_hi),
      .next_valid_i (n_valid),
      .next_lo_i    (n_lo),
      .next_hi_i    (n_hi),
      .head_lo_i    (lo[0]),
      .head_hi_i    (hi[0]),
      .flags_o      (flags[g]),
      .lo_o         (lo[g]),
      .hi_o         (hi[g])
    );

    assign cov_vec[g]   = flags[g].cov;
    assign below_vec[g] = flags[g].below;
    assign above_vec[g] = flags[g].above;
  end

  assign any_cov   = |cov_vec;
  assign any_below = |below_vec;
  assign any_above = |above_vec;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid_q || m_axis_tready;
  assign cell_value = (state_q == ST_IDLE) ? s_axis_tdata[VALUE_BITS-1:0] : value_q;
  assign rpt_last   = ((rpt_idx_q + 1'b1) == count_q);

  // Controller: sequences compare, update and report steps
  always_comb begin
    state_d      = state_q;
    value_d      = value_q;
    count_d      = count_q;
    rpt_idx_d    = rpt_idx_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_lo_d     = out_lo_q;
    out_hi_d     = out_hi_q;
    out_last_d   = out_last_q;
    ctrl.op      = CELL_HOLD;
    ctrl.mode    = UPD_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          value_d = s_axis_tdata[VALUE_BITS-1:0];
          if (s_axis_tuser == OP_ADD) begin
            ctrl.op = CELL_CMP;
            state_d = ST_UPD;
          end else begin
            rpt_idx_d = '0;
            state_d   = ST_RPT;
          end
        end
      end
      ST_UPD: begin
        if (out_free) begin
          ctrl.op      = CELL_UPDATE;
          out_valid_d  = 1'b1;
          out_lo_d     = '0;
          out_hi_d     = '0;
          out_last_d   = 1'b1;
          out_status_d = STATUS_ADDED;
          if (any_cov) begin
            out_status_d = STATUS_COVERED;
          end else if (any_below && any_above) begin
            ctrl.mode = UPD_MERGE;
            count_d   = count_q - 1'b1;
          end else if (any_below) begin
            ctrl.mode = UPD_HIGH;
          end else if (any_above) begin
            ctrl.mode = UPD_LOW;
          end else if (count_q == CW'(MAX_INTERVALS)) begin
            out_status_d = STATUS_FULL;
          end else begin
            ctrl.mode = UPD_INSERT;
            count_d   = count_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_RPT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (count_q == '0) begin
            out_status_d = STATUS_EMPTY;
            out_lo_d     = '0;
            out_hi_d     = '0;
            out_last_d   = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            ctrl.op      = CELL_ROTATE;
            out_status_d = STATUS_REPORT;
            out_lo_d     = lo[0];
            out_hi_d     = hi[0];
            out_last_d   = rpt_last;
            rpt_idx_d    = rpt_idx_q + 1'b1;
            if (rpt_last) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rpt_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rpt_idx_q   <= rpt_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    value_q      <= value_d;
    out_status_q <= out_status_d;
    out_lo_q     <= out_lo_d;
    out_hi_q     <= out_hi_d;
    out_last_q   <= out_last_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OUT_W'({out_hi_q, out_lo_q});

endmodule
